>>> design/combination_lock_controller_top_assert.svh
// Assertion macros for the combination lock controller checker.
// Depends on nothing; included by files that hold concurrent assertions.
`ifndef COMBINATION_LOCK_CONTROLLER_TOP_ASSERT_SVH
`define COMBINATION_LOCK_CONTROLLER_TOP_ASSERT_SVH

// Same-cycle implication, disabled while the reset condition holds.
`define CLC_ASSERT_SAME(lbl, clk, rst, pre, post, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// Next-cycle implication, disabled while the reset condition holds.
`define CLC_ASSERT_NEXT(lbl, clk, rst, pre, post, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

>>> design/clc_pkg.sv
// Shared constants and types of the combination lock controller.
// Depends on nothing; imported by the top level.
`default_nettype none

package clc_pkg;

   localparam int CODE_LENGTH = 4;
   localparam int POS_W       = (CODE_LENGTH > 1) ? $clog2(CODE_LENGTH) : 1;
   localparam int CNT_W       = $clog2(CODE_LENGTH + 1);

   localparam int KEY_W       = 8;
   localparam int RESP_W      = 2;
   localparam int REQ_DATA_W  = 8;
   localparam int RSP_DATA_W  = 8;
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;

   localparam logic [CSR_ADDR_W-1:0] ADDR_RESET_KEY    = 3'd0;
   localparam logic [KEY_W-1:0]      RESET_KEY_DEFAULT = 8'd42;

   localparam logic [POS_W-1:0] POS_LAST = POS_W'(CODE_LENGTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CODE_LENGTH);

   localparam logic [RESP_W-1:0] RESP_WRONG   = 2'd0;
   localparam logic [RESP_W-1:0] RESP_CORRECT = 2'd1;
   localparam logic [RESP_W-1:0] RESP_RESET   = 2'd2;

   typedef enum logic [1:0] {
      MODE_ASSIGN = 2'd0,
      MODE_CHECK  = 2'd1,
      MODE_VERIFY = 2'd2
   } mode_type;

endpackage

`default_nettype wire

>>> design/combination_lock_controller_top.sv
// Top level of the combination lock controller: request stream, response stream, CSR port.
// Depends on clc_pkg.
`default_nettype none

// The block takes one key byte per request and accepts a new request in every cycle,
// unless its input register is held by a response waiting on a stalled output. Each
// request is captured in the input register and checked against the stored code in a
// single compare-and-count step. Any response is loaded into the output register when
// the request leaves the input register. Only the last byte of a check or verify group
// gives a response; an assign group gives none. The input register holds only while a
// response waits on a stalled output. The reset key is written through the CSR port at
// address 0 and should only be changed while the block is idle.
module combination_lock_controller_top (
   input  wire logic                             clock,
   input  wire logic                             reset,
   // Request stream; tdata: key_byte [7:0].
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   input  wire logic [clc_pkg::REQ_DATA_W-1:0]   req_tdata,
   // Response stream; tdata: response [1:0], zeros above.
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   output logic [clc_pkg::RSP_DATA_W-1:0]        rsp_tdata,
   // Configuration port.
   input  wire logic                             csr_psel,
   input  wire logic                             csr_penable,
   input  wire logic                             csr_pwrite,
   input  wire logic [clc_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  wire logic [clc_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [clc_pkg::CSR_DATA_W-1:0]        csr_prdata,
   output logic                                  csr_pready
);
   import clc_pkg::*;

   logic [KEY_W-1:0]  reset_key_ff, reset_key_in;
   logic              in_valid_ff, in_valid_in;
   logic [KEY_W-1:0]  key_ff;
   mode_type          mode_ff, mode_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [CNT_W-1:0]  match_ff, match_in;
   logic [CNT_W-1:0]  rcount_ff, rcount_in;
   logic [KEY_W-1:0]  code_ff [CODE_LENGTH];
   logic              rsp_valid_ff, rsp_valid_in;
   logic [RESP_W-1:0] resp_ff, resp_in;

   logic              advance;
   logic              last;
   logic              hit;
   logic              rkey;
   logic [CNT_W-1:0]  match_sum;
   logic [CNT_W-1:0]  rcount_sum;
   logic              emit;
   logic [RESP_W-1:0] resp_new;
   logic              csr_wr;

   // Configuration port.
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready
                       && (csr_paddr == ADDR_RESET_KEY);
   assign reset_key_in = csr_wr ? csr_pwdata[KEY_W-1:0] : reset_key_ff;
   assign csr_prdata   = (csr_paddr == ADDR_RESET_KEY)
                         ? {{(CSR_DATA_W-KEY_W){1'b0}}, reset_key_ff}
                         : '0;

   // Handshakes.
   assign advance     = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready  = !in_valid_ff || advance;
   assign in_valid_in = (req_tvalid && req_tready) || (in_valid_ff && !advance);

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W-RESP_W){1'b0}}, resp_ff};

   // Group step.
   assign last       = (pos_ff == POS_LAST);
   assign hit        = (key_ff == code_ff[pos_ff]);
   assign rkey       = !hit && (mode_ff == MODE_CHECK) && (key_ff == reset_key_ff);
   assign match_sum  = match_ff + CNT_W'(hit);
   assign rcount_sum = rcount_ff + CNT_W'(rkey);

   always_comb begin
      mode_in   = mode_ff;
      pos_in    = pos_ff;
      match_in  = match_ff;
      rcount_in = rcount_ff;
      emit      = 1'b0;
      resp_new  = RESP_WRONG;
      if (advance) begin
         unique case (mode_ff)
            MODE_ASSIGN: begin
               if (last) begin
                  mode_in   = MODE_CHECK;
                  pos_in    = '0;
                  match_in  = '0;
                  rcount_in = '0;
               end else begin
                  pos_in = pos_ff + POS_W'(1);
               end
            end
            MODE_CHECK, MODE_VERIFY: begin
               if (!last) begin
                  pos_in    = pos_ff + POS_W'(1);
                  match_in  = match_sum;
                  rcount_in = rcount_sum;
               end else begin
                  pos_in    = '0;
                  match_in  = '0;
                  rcount_in = '0;
                  emit      = 1'b1;
                  if (mode_ff == MODE_CHECK) begin
                     if (match_sum == CNT_FULL) begin
                        resp_new = RESP_CORRECT;
                     end else if (rcount_sum == CNT_FULL) begin
                        resp_new = RESP_RESET;
                        mode_in  = MODE_VERIFY;
                     end
                  end else begin
                     if (match_sum == CNT_FULL) begin
                        resp_new = RESP_CORRECT;
                        mode_in  = MODE_ASSIGN;
                     end else begin
                        mode_in  = MODE_CHECK;
                     end
                  end
               end
            end
            default: begin
               mode_in   = MODE_ASSIGN;
               pos_in    = '0;
               match_in  = '0;
               rcount_in = '0;
            end
         endcase
      end
   end

   assign rsp_valid_in = (rsp_valid_ff && !rsp_tready) || emit;
   assign resp_in      = emit ? resp_new : resp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         reset_key_ff <= RESET_KEY_DEFAULT;
         in_valid_ff  <= 1'b0;
         mode_ff      <= MODE_ASSIGN;
         pos_ff       <= '0;
         match_ff     <= '0;
         rcount_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         reset_key_ff <= reset_key_in;
         in_valid_ff  <= in_valid_in;
         mode_ff      <= mode_in;
         pos_ff       <= pos_in;
         match_ff     <= match_in;
         rcount_ff    <= rcount_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         key_ff <= req_tdata[KEY_W-1:0];
      end
      resp_ff <= resp_in;
      if (advance && (mode_ff == MODE_ASSIGN)) begin
         code_ff[pos_ff] <= key_ff;
      end
   end

endmodule

`default_nettype wire

>>> design/clc_checker.sv
// Port-level checker of the combination lock controller, bound to the top level.
// Depends on combination_lock_controller_top_assert.svh and the top level's ports.
`default_nettype none

`include "combination_lock_controller_top_assert.svh"

module clc_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_tvalid,
   input wire logic       req_tready,
   input wire logic       rsp_tvalid,
   input wire logic       rsp_tready,
   input wire logic [7:0] rsp_tdata
);

   `CLC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "Stalled response changed or was dropped.")

   `CLC_ASSERT_NEXT(a_reset_clears, clock, 1'b0, reset, !rsp_tvalid, "Response valid straight after reset.")

   `CLC_ASSERT_SAME(a_rsp_follows_req, clock, reset, $rose(rsp_tvalid), $past(req_tvalid && req_tready, 2), "New response without a request two cycles earlier.")

   `CLC_ASSERT_SAME(a_rsp_code, clock, reset, rsp_tvalid, (rsp_tdata[1:0] != 2'd3) && (rsp_tdata[7:2] == 6'd0), "Response carries an undefined code.")

endmodule

bind combination_lock_controller_top clc_checker u_clc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire

>>> test/combination_lock_controller_checker.sv
// Checker for the combination lock controller: watches the request, response and CSR
// channels, predicts each response and compares it with the one the block returns.
// Depends on clc_pkg.
`timescale 1ns / 1ps

module combination_lock_controller_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   input  logic                           req_tready,
   input  logic [clc_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   input  logic [clc_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic                           csr_pready,
   input  logic [clc_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [clc_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output int                             mismatches,
   output int                             responses_pending
);
   import clc_pkg::*;

   mode_type            lock_mode;
   logic [POS_W-1:0]    key_pos;
   logic [CNT_W-1:0]    match_tally;
   logic [CNT_W-1:0]    reset_tally;
   logic [KEY_W-1:0]    code_store [CODE_LENGTH];
   logic [KEY_W-1:0]    change_key;
   logic [RESP_W-1:0]   responses_due [$];
   logic [RESP_W-1:0]   want;
   logic [RSP_DATA_W-1:0] want_data;

   task automatic clear_group();
      key_pos     = '0;
      match_tally = '0;
      reset_tally = '0;
   endtask

   task automatic advance_lock(input logic [KEY_W-1:0] key);
      logic is_last;
      is_last = (key_pos == POS_LAST);
      if (lock_mode == MODE_ASSIGN) begin
         code_store[key_pos] = key;
         if (is_last) begin
            lock_mode = MODE_CHECK;
            clear_group();
         end else begin
            key_pos = key_pos + POS_W'(1);
         end
      end else begin
         // A byte that matches its code byte never counts as a reset key as well.
         if (key == code_store[key_pos])
            match_tally = match_tally + CNT_W'(1);
         else if (lock_mode == MODE_CHECK && key == change_key)
            reset_tally = reset_tally + CNT_W'(1);
         if (!is_last) begin
            key_pos = key_pos + POS_W'(1);
         end else begin
            if (lock_mode == MODE_CHECK) begin
               if (match_tally == CNT_FULL) begin
                  responses_due.push_back(RESP_CORRECT);
               end else if (reset_tally == CNT_FULL) begin
                  responses_due.push_back(RESP_RESET);
                  lock_mode = MODE_VERIFY;
               end else begin
                  responses_due.push_back(RESP_WRONG);
               end
            end else if (match_tally == CNT_FULL) begin
               responses_due.push_back(RESP_CORRECT);
               lock_mode = MODE_ASSIGN;
            end else begin
               responses_due.push_back(RESP_WRONG);
               lock_mode = MODE_CHECK;
            end
            clear_group();
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         lock_mode  = MODE_ASSIGN;
         clear_group();
         change_key = RESET_KEY_DEFAULT;
         responses_due.delete();
         mismatches = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (responses_due.size() == 0) begin
               $display("%0t: unexpected response, expected none, actual %h",
                        $time, rsp_tdata);
               mismatches++;
            end else begin
               want = responses_due.pop_front();
               want_data = '0;
               want_data[RESP_W-1:0] = want;
               if (rsp_tdata !== want_data) begin
                  $display("%0t: response mismatch, expected %h, actual %h",
                           $time, want_data, rsp_tdata);
                  mismatches++;
               end
            end
         end
         if (req_tvalid && req_tready)
            advance_lock(req_tdata[KEY_W-1:0]);
         if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
             csr_paddr == ADDR_RESET_KEY)
            change_key = csr_pwdata[KEY_W-1:0];
      end
      responses_pending = responses_due.size();
   end

endmodule

>>> test/combination_lock_controller_top_tb.sv
// Testbench top for the combination lock controller: clock, reset, key stimulus in whole
// groups, CSR writes between phases and the final verdict.
// Depends on clc_pkg, combination_lock_controller_top and combination_lock_controller_checker.
`timescale 1ns / 1ps

module combination_lock_controller_top_tb;
   import clc_pkg::*;

   localparam int GROUP_BITS     = KEY_W * CODE_LENGTH;
   localparam int NUM_PHASES     = 6;
   localparam int PHASE_GROUPS   = 42;
   localparam int DRAIN_CYCLES   = 8;
   localparam int LONG_HOLD      = 300;
   localparam logic [CSR_ADDR_W-1:0] ADDR_UNMAPPED = 3'd4;

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_tvalid  = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata   = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready  = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_psel    = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata  = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   int mismatches;
   int responses_pending;
   int req_gap_max = 0;
   int rsp_gap_max = 0;

   // Stimulus view of the lock, used only to choose meaningful key groups.
   mode_type              sh_mode = MODE_ASSIGN;
   logic [GROUP_BITS-1:0] sh_code = '0;
   logic [KEY_W-1:0]      sh_rkey = RESET_KEY_DEFAULT;

   combination_lock_controller_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   combination_lock_controller_checker lock_checker (
      .clock             (clock),
      .reset             (reset),
      .req_tvalid        (req_tvalid),
      .req_tready        (req_tready),
      .req_tdata         (req_tdata),
      .rsp_tvalid        (rsp_tvalid),
      .rsp_tready        (rsp_tready),
      .rsp_tdata         (rsp_tdata),
      .csr_psel          (csr_psel),
      .csr_penable       (csr_penable),
      .csr_pwrite        (csr_pwrite),
      .csr_pready        (csr_pready),
      .csr_paddr         (csr_paddr),
      .csr_pwdata        (csr_pwdata),
      .mismatches        (mismatches),
      .responses_pending (responses_pending)
   );

   always #5 clock = ~clock;

   task automatic send_key(input logic [KEY_W-1:0] key);
      int gap;
      gap = $urandom_range(0, req_gap_max);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= key;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic send_group(input logic [GROUP_BITS-1:0] grp);
      int hits;
      int rkeys;
      logic [KEY_W-1:0] key;
      hits  = 0;
      rkeys = 0;
      for (int i = 0; i < CODE_LENGTH; i++) begin
         key = grp[i*KEY_W +: KEY_W];
         send_key(key);
         if (key == sh_code[i*KEY_W +: KEY_W])
            hits++;
         else if (key == sh_rkey)
            rkeys++;
      end
      case (sh_mode)
         MODE_ASSIGN: begin
            sh_code = grp;
            sh_mode = MODE_CHECK;
         end
         MODE_CHECK: begin
            if (hits != CODE_LENGTH && rkeys == CODE_LENGTH)
               sh_mode = MODE_VERIFY;
         end
         default: begin
            sh_mode = (hits == CODE_LENGTH) ? MODE_ASSIGN : MODE_CHECK;
         end
      endcase
   endtask

   function automatic logic [GROUP_BITS-1:0] draw_group();
      logic [GROUP_BITS-1:0] grp;
      logic [KEY_W-1:0]      flip;
      int                    roll;
      int                    slot;
      roll = $urandom_range(0, 99);
      slot = $urandom_range(0, CODE_LENGTH - 1);
      flip = KEY_W'($urandom_range(1, 255));
      for (int i = 0; i < CODE_LENGTH; i++)
         grp[i*KEY_W +: KEY_W] = KEY_W'($urandom_range(0, 255));
      case (sh_mode)
         MODE_ASSIGN: begin
            if (roll < 20) begin
               for (int i = 0; i < CODE_LENGTH; i++)
                  if ($urandom_range(0, 1))
                     grp[i*KEY_W +: KEY_W] = sh_rkey;
            end else if (roll < 35) begin
               for (int i = 0; i < CODE_LENGTH; i++)
                  case ($urandom_range(0, 2))
                     0:       grp[i*KEY_W +: KEY_W] = 8'h00;
                     1:       grp[i*KEY_W +: KEY_W] = 8'hFF;
                     default: grp[i*KEY_W +: KEY_W] = sh_rkey;
                  endcase
            end
         end
         MODE_CHECK: begin
            if (roll < 35) begin
               grp = sh_code;
            end else if (roll < 60) begin
               grp = {CODE_LENGTH{sh_rkey}};
            end else if (roll < 72) begin
               grp = sh_code;
               grp[slot*KEY_W +: KEY_W] = sh_code[slot*KEY_W +: KEY_W] ^ flip;
            end else if (roll < 82) begin
               grp = sh_code;
               grp[slot*KEY_W +: KEY_W] = sh_rkey;
            end else if (roll < 90) begin
               grp = {CODE_LENGTH{sh_rkey}};
               grp[slot*KEY_W +: KEY_W] = sh_rkey ^ flip;
            end
         end
         default: begin
            if (roll < 50) begin
               grp = sh_code;
            end else if (roll < 80) begin
               grp = sh_code;
               grp[slot*KEY_W +: KEY_W] = sh_code[slot*KEY_W +: KEY_W] ^ flip;
            end
         end
      endcase
      return grp;
   endfunction

   task automatic write_csr(input logic [CSR_ADDR_W-1:0] addr,
                            input logic [CSR_DATA_W-1:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      if (addr == ADDR_RESET_KEY)
         sh_rkey = data[KEY_W-1:0];
   endtask

   // Waits until every response has arrived and the pipeline has run dry.
   task automatic settle();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (responses_pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Response side: a random hold-off per response, and two long hold-offs that let the
   // block fill up and stall its request input.
   initial begin
      int taken;
      int gap;
      taken = 0;
      while (reset) @(posedge clock);
      forever begin
         if (taken == 30 || taken == 180)
            gap = LONG_HOLD;
         else
            gap = $urandom_range(0, rsp_gap_max);
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         taken++;
      end
   end

   initial begin
      logic [GROUP_BITS-1:0] first_code;
      logic [CSR_DATA_W-1:0] wdata;
      logic [KEY_W-1:0]      phase_key;
      for (int i = 0; i < CODE_LENGTH; i++)
         first_code[i*KEY_W +: KEY_W] = (i % 2 == 0) ? 8'h00 : 8'hFF;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      req_gap_max = 3;
      rsp_gap_max = 3;

      // Directed walk through every mode and response.
      send_group(first_code);
      send_group({CODE_LENGTH{sh_rkey}});
      send_group({CODE_LENGTH{8'hFF}});
      send_group({CODE_LENGTH{sh_rkey}});
      send_group(first_code);
      // A code made of reset keys: matching bytes count as matches only.
      send_group({CODE_LENGTH{RESET_KEY_DEFAULT}});
      send_group({CODE_LENGTH{RESET_KEY_DEFAULT}});

      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         settle();
         case (phase)
            0: begin req_gap_max = 15; rsp_gap_max = 15; phase_key = RESET_KEY_DEFAULT; end
            1: begin req_gap_max = 0;  rsp_gap_max = 0;  phase_key = 8'h00; end
            2: begin req_gap_max = 0;  rsp_gap_max = 15; phase_key = 8'hFF; end
            3: begin
               req_gap_max = 15;
               rsp_gap_max = 0;
               phase_key   = KEY_W'($urandom_range(0, 255));
            end
            4: begin
               req_gap_max = $urandom_range(0, 15);
               rsp_gap_max = $urandom_range(0, 15);
               phase_key   = KEY_W'($urandom_range(0, 255));
            end
            default: begin
               req_gap_max = $urandom_range(0, 15);
               rsp_gap_max = $urandom_range(0, 15);
               phase_key   = RESET_KEY_DEFAULT;
            end
         endcase
         if (phase != 0) begin
            wdata = $urandom;
            wdata[KEY_W-1:0] = phase_key;
            write_csr(ADDR_RESET_KEY, wdata);
         end
         if (phase == 3)
            write_csr(ADDR_UNMAPPED, $urandom);
         repeat (PHASE_GROUPS) send_group(draw_group());
      end

      settle();
      if (mismatches == 0 && responses_pending == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("Some tests failed");
      $finish;
   end

endmodule
